/* design/fcma_pkg.sv */
package fcma_pkg;

  localparam int WINDOW    = 25;
  localparam int NCH       = 4;
  localparam int SMP_W     = 16;
  localparam int SUM_W     = $clog2(WINDOW * 65535 + 1);
  localparam int POS_W     = $clog2(WINDOW);
  localparam int RING_W    = NCH * SMP_W;
  localparam int RECIP_K   = SUM_W;
  localparam int RECIP_M   = (2 ** RECIP_K) / WINDOW;
  localparam int FRAME_LEN = 10;
  localparam int BPOS_W    = 4;

  localparam logic [7:0]        FRAME_HDR = 8'h5A;
  localparam logic [BPOS_W-1:0] BP_HDR    = BPOS_W'(0);
  localparam logic [BPOS_W-1:0] BP_CHK    = BPOS_W'(FRAME_LEN - 1);

  typedef logic [NCH-1:0][SMP_W-1:0] smp_vec_t;
  typedef logic [NCH-1:0][SUM_W-1:0] sum_vec_t;

endpackage

/* design/fcma_ram.sv */
module fcma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/fcma_acc.sv */
module fcma_acc import fcma_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  smp_vec_t in_smp,
  output logic     out_valid,
  input  logic     out_ready,
  output sum_vec_t out_sum
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [WINDOW-1:0] vld_r, vld_nxt;
  logic              a_v_r, a_v_nxt;
  smp_vec_t          a_smp_r;
  logic [POS_W-1:0]  a_pos_r;
  logic              a_ok_r;
  sum_vec_t          sum_r, sum_nxt;
  logic              m_v_r, m_v_nxt;
  logic [RING_W-1:0] rd_data;
  smp_vec_t          old_smp;
  logic              in_fire, a_go;

  assign a_go     = a_v_r && (!m_v_r || out_ready);
  assign in_ready = !a_v_r || a_go;
  assign in_fire  = in_valid && in_ready;

  // ring entries never written since reset read as zero
  assign old_smp = a_ok_r ? smp_vec_t'(rd_data) : '0;

  fcma_ram #(.WIDTH(RING_W), .DEPTH(WINDOW)) u_ring (
    .clk   (clk),
    .we    (a_go),
    .waddr (a_pos_r),
    .wdata (RING_W'(a_smp_r)),
    .re    (in_fire),
    .raddr (pos_r),
    .rdata (rd_data)
  );

  always_comb begin
    pos_nxt = pos_r;
    vld_nxt = vld_r;
    sum_nxt = sum_r;
    a_v_nxt = a_v_r;
    m_v_nxt = m_v_r;
    if (out_ready) begin
      m_v_nxt = 1'b0;
    end
    if (a_go) begin
      for (int c = 0; c < NCH; c++) begin
        sum_nxt[c] = sum_r[c] - SUM_W'(old_smp[c]) + SUM_W'(a_smp_r[c]);
      end
      vld_nxt[a_pos_r] = 1'b1;
      a_v_nxt          = 1'b0;
      m_v_nxt          = 1'b1;
    end
    if (in_fire) begin
      a_v_nxt = 1'b1;
      pos_nxt = (pos_r == POS_W'(WINDOW - 1)) ? '0 : pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      vld_r <= '0;
      sum_r <= '0;
      a_v_r <= 1'b0;
      m_v_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      vld_r <= vld_nxt;
      sum_r <= sum_nxt;
      a_v_r <= a_v_nxt;
      m_v_r <= m_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_smp_r <= in_smp;
      a_pos_r <= pos_r;
      a_ok_r  <= vld_r[pos_r];
    end
  end

  assign out_valid = m_v_r;
  assign out_sum   = sum_r;

endmodule

/* design/fcma_div.sv */
module fcma_div import fcma_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sum_vec_t in_sum,
  output logic     out_valid,
  input  logic     out_ready,
  output smp_vec_t out_avg
);

  localparam logic [RECIP_K-1:0] RECIP = RECIP_K'(RECIP_M);

  logic     p_v_r, p_v_nxt;
  smp_vec_t p_q_r, q_est;
  sum_vec_t p_sum_r;
  logic     o_v_r, o_v_nxt;
  smp_vec_t o_avg_r, q_fix;
  logic     p_go, in_fire;

  assign p_go     = p_v_r && (!o_v_r || out_ready);
  assign in_ready = !p_v_r || p_go;
  assign in_fire  = in_valid && in_ready;

  // reciprocal estimate, low by at most one
  always_comb begin
    logic [SUM_W+RECIP_K-1:0] prod;
    for (int c = 0; c < NCH; c++) begin
      prod     = (SUM_W + RECIP_K)'(in_sum[c]) * (SUM_W + RECIP_K)'(RECIP);
      q_est[c] = prod[RECIP_K +: SMP_W];
    end
  end

  always_comb begin
    logic [SUM_W-1:0] rem;
    for (int c = 0; c < NCH; c++) begin
      rem      = p_sum_r[c] - SUM_W'(p_q_r[c]) * SUM_W'(WINDOW);
      q_fix[c] = (rem >= SUM_W'(WINDOW)) ? p_q_r[c] + SMP_W'(1) : p_q_r[c];
    end
  end

  always_comb begin
    p_v_nxt = p_v_r;
    o_v_nxt = o_v_r;
    if (out_ready) begin
      o_v_nxt = 1'b0;
    end
    if (p_go) begin
      p_v_nxt = 1'b0;
      o_v_nxt = 1'b1;
    end
    if (in_fire) begin
      p_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      p_v_r <= p_v_nxt;
      o_v_r <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p_q_r   <= q_est;
      p_sum_r <= in_sum;
    end
    if (p_go) begin
      o_avg_r <= q_fix;
    end
  end

  assign out_valid = o_v_r;
  assign out_avg   = o_avg_r;

endmodule

/* design/fcma_framer.sv */
module fcma_framer import fcma_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  smp_vec_t   in_avg,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_end
);

  logic              f_v_r, f_v_nxt;
  smp_vec_t          f_avg_r;
  logic [RING_W-1:0] f_flat;
  logic [BPOS_W-1:0] bpos_r, bpos_nxt;
  logic [7:0]        chk_r, chk_nxt;
  logic [2:0]        didx;
  logic              out_fire, is_last, in_fire;

  assign f_flat   = RING_W'(f_avg_r);
  assign didx     = 3'(bpos_r - BPOS_W'(1));
  assign is_last  = (bpos_r == BP_CHK);
  assign out_fire = f_v_r && out_ready;
  assign in_ready = !f_v_r || (out_fire && is_last);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    case (bpos_r)
      BP_HDR:  out_byte = FRAME_HDR;
      BP_CHK:  out_byte = chk_r;
      default: out_byte = f_flat[8*didx +: 8];
    endcase
  end

  always_comb begin
    f_v_nxt  = f_v_r;
    bpos_nxt = bpos_r;
    chk_nxt  = chk_r;
    if (out_fire) begin
      if (is_last) begin
        f_v_nxt  = 1'b0;
        bpos_nxt = BP_HDR;
        chk_nxt  = FRAME_HDR;
      end else begin
        bpos_nxt = bpos_r + BPOS_W'(1);
        if (bpos_r != BP_HDR) begin
          chk_nxt = chk_r + out_byte;
        end
      end
    end
    if (in_fire) begin
      f_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r  <= 1'b0;
      bpos_r <= BP_HDR;
      chk_r  <= FRAME_HDR;
    end else begin
      f_v_r  <= f_v_nxt;
      bpos_r <= bpos_nxt;
      chk_r  <= chk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      f_avg_r <= in_avg;
    end
  end

  assign out_valid = f_v_r;
  assign out_end   = f_v_r && is_last;

endmodule

/* design/four_channel_moving_average_framer_unit.sv */
// the header word leaves once the measurement has passed the accumulator stage,
// sum register, divider estimate and output registers and framer; each measurement
// gives a 10-word frame, and the byte serializer takes the next averages as the last
// frame word leaves, while the ring and divider already work on the next measurement
// reset (rst_n low, synchronous): sums, ring valid bits, position and frame state
// clear at once; no clearing pass, the block takes input in the first cycle after
module four_channel_moving_average_framer_unit import fcma_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // x_high_time [15:0], x_period [31:16], y_high_time [47:32], y_period [63:48]
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // frame_byte [7:0]
  output logic [7:0]  out_tdata,
  output logic        out_tlast
);

  logic     acc_valid, acc_ready;
  sum_vec_t acc_sum;
  logic     div_valid, div_ready;
  smp_vec_t div_avg;

  fcma_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_smp    (smp_vec_t'(in_tdata)),
    .out_valid (acc_valid),
    .out_ready (acc_ready),
    .out_sum   (acc_sum)
  );

  fcma_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (acc_valid),
    .in_ready  (acc_ready),
    .in_sum    (acc_sum),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_avg   (div_avg)
  );

  fcma_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_avg    (div_avg),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_end   (out_tlast)
  );

endmodule

/* design/fcma_chk.sv */
module fcma_chk import fcma_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast
);

  logic [BPOS_W-1:0] cnt_r;
  logic [7:0]        sum_r;
  logic              fire;

  assign fire = out_tvalid && out_tready;

  // word count and checksum as seen on the output port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= BP_HDR;
      sum_r <= 8'h00;
    end else if (fire) begin
      if (out_tlast) begin
        cnt_r <= BP_HDR;
        sum_r <= 8'h00;
      end else begin
        cnt_r <= cnt_r + BPOS_W'(1);
        sum_r <= sum_r + out_tdata;
      end
    end
  end

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word shown right after reset");

  a_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && cnt_r == BP_HDR |-> out_tdata == FRAME_HDR)
    else $error("frame does not open with the header word");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tlast == (cnt_r == BP_CHK))
    else $error("tlast not on the tenth word of a frame");

  a_chk: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == sum_r)
    else $error("checksum word does not match frame contents");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output word changed");

endmodule

bind four_channel_moving_average_framer_unit fcma_chk u_fcma_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import fcma_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned RAND_ITEMS  = 105;

  // running boxcar state per channel and the frame words still owed by the block
  class avg_frame_tracker;
    smp_vec_t         ring [WINDOW];
    logic [SUM_W-1:0] sums [NCH];
    int unsigned      oldest;
    logic [8:0]       frame_words_due [$];  // {last, byte}
    int unsigned      errors;

    function new();
      foreach (ring[i]) ring[i] = '0;
      foreach (sums[c]) sums[c] = '0;
      oldest = 0;
      errors = 0;
    endfunction

    function void note_measurement(smp_vec_t m);
      logic [SMP_W-1:0] avg;
      logic [7:0]       chk;
      for (int c = 0; c < NCH; c++) begin
        sums[c] = sums[c] - SUM_W'(ring[oldest][c]) + SUM_W'(m[c]);
        ring[oldest][c] = m[c];
      end
      oldest = (oldest == WINDOW - 1) ? 0 : oldest + 1;
      chk = FRAME_HDR;
      frame_words_due.push_back({1'b0, FRAME_HDR});
      for (int c = 0; c < NCH; c++) begin
        avg = SMP_W'(sums[c] / WINDOW);
        frame_words_due.push_back({1'b0, avg[7:0]});
        frame_words_due.push_back({1'b0, avg[15:8]});
        chk = chk + avg[7:0] + avg[15:8];
      end
      frame_words_due.push_back({1'b1, chk});
    endfunction

    function void check_word(logic [7:0] b, logic last);
      logic [8:0] due;
      if (frame_words_due.size() == 0) begin
        $display("%0t: word with nothing due: expected none, actual byte %h last %b",
                 $time, b, last);
        errors++;
      end else begin
        due = frame_words_due.pop_front();
        if (b !== due[7:0]) begin
          $display("%0t: frame byte: expected %h, actual %h", $time, due[7:0], b);
          errors++;
        end
        if (last !== due[8]) begin
          $display("%0t: frame end: expected %b, actual %b", $time, due[8], last);
          errors++;
        end
      end
    endfunction

    function int pending();
      return frame_words_due.size();
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  logic        idle_on  = 1'b1;
  logic        hold_req = 1'b0;

  avg_frame_tracker tracker = new();

  four_channel_moving_average_framer_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 255));
      2:       return 16'($urandom_range(16'hFF00, 16'hFFFF));
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  // offer one measurement word, then maybe leave a gap
  task automatic send_measurement(input logic [63:0] w);
    in_tdata  <= w;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_measurement(smp_vec_t'(w));
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  initial begin : receive_words
    int unsigned stall_left;
    bit          hold_done;
    stall_left = 0;
    hold_done  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) tracker.check_word(out_tdata, out_tlast);
      if (hold_req && !hold_done) begin
        hold_done  = 1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("four_channel_moving_average_framer_unit: mismatch");
    $finish;
  end

  initial begin : stimulus
    logic [63:0] w;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // warm-up from an empty ring, then push the sums toward full scale
    send_measurement(64'h0);
    repeat (20) send_measurement({4{16'hFFFF}});
    send_measurement({16'h0001, 16'h8000, 16'h00FF, 16'hFF00});
    send_measurement({16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
    send_measurement({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
    send_measurement({16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF});

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == 10) hold_req <= 1'b1;
      if (i == 70) begin
        if (in_tvalid) in_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
      end
      if (i == 80) idle_on <= 1'b0;
      // a full window of maximum counts drives every sum to its ceiling
      if (i >= 40 && i < 66) w = {4{16'hFFFF}};
      else w = {rand_field(), rand_field(), rand_field(), rand_field()};
      send_measurement(w);
    end
    in_tvalid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("four_channel_moving_average_framer_unit: match");
    else
      $display("four_channel_moving_average_framer_unit: mismatch");
    $finish;
  end

endmodule
